### hdl/ocg_pkg.sv
// ----------------------------------------------------------------------------
// ocg_pkg
// shared types, widths and codes of the oven countdown and temperature gauge
// ----------------------------------------------------------------------------
package ocg_pkg;

	// field widths
	localparam int ACTION_W   = 3;
	localparam int ADC_W      = 10;
	localparam int SEC_W      = 8;
	localparam int TEMP_W     = 10;
	localparam int THR_W      = 10;
	localparam int DIGIT_W    = 4;

	// scaling: full scale maps to this many tenths of a degree
	localparam int TEMP_MAX   = 1000;
	localparam int PROD_W     = ADC_W + $clog2(TEMP_MAX + 1);

	// parameter defaults
	localparam int QUARTERS_PER_SECOND_DEF = 4;
	localparam int ADC_FULL_SCALE_DEF      = 1023;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_SECONDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_SECONDS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LED_THRESHOLD = 2'd2;

	localparam logic [SEC_W-1:0] SHORT_SECONDS_RST = 8'd10;
	localparam logic [SEC_W-1:0] LONG_SECONDS_RST  = 8'd60;
	localparam logic [THR_W-1:0] LED_THRESHOLD_RST = 10'd500;

	// stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int RES_W       = 2 + SEC_W + TEMP_W + 1 + 3 * DIGIT_W + 1;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [ACTION_W-1:0] {
		ACT_MODE  = 3'd0,
		ACT_START = 3'd1,
		ACT_SEC   = 3'd2,
		ACT_QTR   = 3'd3,
		ACT_ADC   = 3'd4
	} action_t;

	typedef struct packed {
		logic               led_on;
		logic [DIGIT_W-1:0] digit_tenths;
		logic [DIGIT_W-1:0] digit_units;
		logic [DIGIT_W-1:0] digit_tens;
		logic               digit_hundreds;
		logic [TEMP_W-1:0]  temperature_tenths;
		logic [SEC_W-1:0]   seconds_left;
		logic               long_mode;
		logic               running;
	} result_t;

endpackage

### hdl/ocg_temp.sv
// ----------------------------------------------------------------------------
// ocg_temp
// input register and converter scaling pipeline: adc * 1000 / full scale
// ----------------------------------------------------------------------------
module ocg_temp #(
	parameter int ADC_FULL_SCALE = ocg_pkg::ADC_FULL_SCALE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ocg_pkg::action_t            in_action,
	input  logic [ocg_pkg::ADC_W-1:0]   in_adc,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ocg_pkg::action_t            out_action,
	output logic [ocg_pkg::TEMP_W-1:0]  out_temp
);
	import ocg_pkg::*;

	// reciprocal of full scale, pre-scaled by 1000 and by 2**PROD_W
	localparam longint unsigned RECIP = (longint'(TEMP_MAX) << PROD_W) / ADC_FULL_SCALE;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int QUO_W   = PROD_W - $clog2(ADC_FULL_SCALE + 1) + 1;
	localparam int MUL_W   = PROD_W + QUO_W;
	localparam int CMP_W   = (QUO_W > TEMP_W) ? QUO_W : TEMP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	logic              v_s1, v_s2, v_s3;
	logic              rdy_s1, rdy_s2, rdy_s3;
	action_t           action_s1, action_s2, action_s3;
	logic [ADC_W-1:0]  adc_s1, adc_s2;
	logic [QUO_W-1:0]  quo_s2;
	logic [TEMP_W-1:0] temp_s3;

	logic [MUL_W-1:0]  est_mul;
	logic [QUO_W-1:0]  quo_est;
	logic [PROD_W-1:0] prod, back, rem;
	logic [QUO_W-1:0]  quo_fix;
	logic [TEMP_W-1:0] temp_sat;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// estimate, at most one below the true quotient
	assign est_mul = MUL_W'(adc_s1) * MUL_W'(RECIP_C);
	assign quo_est = est_mul[PROD_W +: QUO_W];

	// one correction step, then clamp at full scale
	assign prod = PROD_W'(adc_s2) * PROD_W'(TEMP_MAX);
	assign back = PROD_W'(quo_s2) * PROD_W'(ADC_FULL_SCALE);
	assign rem  = prod - back;
	assign quo_fix = (rem >= PROD_W'(ADC_FULL_SCALE)) ? quo_s2 + QUO_W'(1) : quo_s2;
	assign temp_sat = (CMP_W'(quo_fix) > CMP_W'(TEMP_MAX)) ?
		TEMP_W'(TEMP_MAX) : TEMP_W'(CMP_W'(quo_fix));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			action_s1 <= in_action;
			adc_s1    <= in_adc;
		end
		if (rdy_s2 && v_s1) begin
			action_s2 <= action_s1;
			adc_s2    <= adc_s1;
			quo_s2    <= quo_est;
		end
		if (rdy_s3 && v_s2) begin
			action_s3 <= action_s2;
			temp_s3   <= temp_sat;
		end
	end

	assign out_valid  = v_s3;
	assign out_action = action_s3;
	assign out_temp   = temp_s3;

endmodule

### hdl/ocg_ctrl.sv
// ----------------------------------------------------------------------------
// ocg_ctrl
// countdown and gauge state, configuration registers and result register
// ----------------------------------------------------------------------------
module ocg_ctrl #(
	parameter int QUARTERS_PER_SECOND = ocg_pkg::QUARTERS_PER_SECOND_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ocg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ocg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ocg_pkg::action_t                in_action,
	input  logic [ocg_pkg::TEMP_W-1:0]      in_temp,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ocg_pkg::result_t                out_result
);
	import ocg_pkg::*;

	localparam int QC_W = $clog2(QUARTERS_PER_SECOND);

	// configuration
	logic [SEC_W-1:0] short_seconds_q, long_seconds_q;
	logic [THR_W-1:0] led_threshold_q;

	// state
	logic               mode_long_q, counting_q, indicator_q;
	logic [SEC_W-1:0]   remaining_q;
	logic [QC_W-1:0]    quarter_q;
	logic [TEMP_W-1:0]  temp_q;
	logic               hund_q;
	logic [DIGIT_W-1:0] tens_q, units_q, tenths_q;

	logic               mode_long_d, counting_d, indicator_d;
	logic [SEC_W-1:0]   remaining_d;
	logic [QC_W-1:0]    quarter_d;
	logic               sample_take;

	logic               out_valid_q;
	result_t            out_q;
	logic               accept;

	// decimal split of the incoming temperature, x*205>>11 is x/10 here
	logic [17:0]        deg_mul;
	logic [6:0]         deg;
	logic [14:0]        tdeg_mul;
	logic [3:0]         tdeg;
	logic [TEMP_W-1:0]  tenths_full;
	logic [6:0]         units_full;
	logic               hund_w;
	logic [DIGIT_W-1:0] tens_w, units_w, tenths_w;

	logic [SEC_W-1:0]   rem_dec;
	logic [QC_W:0]      quarter_inc;

	assign deg_mul     = 18'(in_temp) * 18'd205;
	assign deg         = deg_mul[17:11];
	assign tdeg_mul    = 15'(deg) * 15'd205;
	assign tdeg        = tdeg_mul[14:11];
	assign tenths_full = in_temp - TEMP_W'(deg) * TEMP_W'(10);
	assign units_full  = deg - 7'(tdeg) * 7'd10;
	assign tenths_w    = tenths_full[DIGIT_W-1:0];
	assign units_w     = units_full[DIGIT_W-1:0];
	assign tens_w      = (tdeg >= 4'd10) ? tdeg - 4'd10 : tdeg;
	assign hund_w      = (in_temp == TEMP_W'(TEMP_MAX));

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign rem_dec     = (remaining_q != '0) ? remaining_q - SEC_W'(1) : remaining_q;
	assign quarter_inc = (QC_W + 1)'(quarter_q) + (QC_W + 1)'(1);

	always_comb begin
		mode_long_d = mode_long_q;
		counting_d  = counting_q;
		indicator_d = indicator_q;
		remaining_d = remaining_q;
		quarter_d   = quarter_q;
		sample_take = 1'b0;
		case (in_action)
			ACT_MODE: begin
				if (!counting_q) mode_long_d = !mode_long_q;
			end
			ACT_START: begin
				if (!counting_q) begin
					counting_d  = 1'b1;
					remaining_d = mode_long_q ? long_seconds_q : short_seconds_q;
					quarter_d   = '0;
					indicator_d = 1'b0;
				end
			end
			ACT_SEC: begin
				if (counting_q && mode_long_q) begin
					remaining_d = rem_dec;
					if (rem_dec == '0) begin
						counting_d  = 1'b0;
						indicator_d = 1'b0;
					end
				end
			end
			ACT_QTR: begin
				if (counting_q && !mode_long_q) begin
					if (quarter_inc >= (QC_W + 1)'(QUARTERS_PER_SECOND)) begin
						quarter_d   = '0;
						remaining_d = rem_dec;
						if (rem_dec == '0) begin
							counting_d  = 1'b0;
							indicator_d = 1'b0;
						end
					end else begin
						quarter_d = quarter_inc[QC_W-1:0];
					end
				end
			end
			ACT_ADC: begin
				if (counting_q) begin
					sample_take = 1'b1;
					indicator_d = (in_temp > led_threshold_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_seconds_q <= SHORT_SECONDS_RST;
			long_seconds_q  <= LONG_SECONDS_RST;
			led_threshold_q <= LED_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_SECONDS: short_seconds_q <= cfg_data[SEC_W-1:0];
				REG_LONG_SECONDS:  long_seconds_q  <= cfg_data[SEC_W-1:0];
				REG_LED_THRESHOLD: led_threshold_q <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_long_q <= 1'b0;
			counting_q  <= 1'b0;
			indicator_q <= 1'b0;
			remaining_q <= '0;
			quarter_q   <= '0;
			temp_q      <= '0;
			hund_q      <= 1'b0;
			tens_q      <= '0;
			units_q     <= '0;
			tenths_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_long_q <= mode_long_d;
				counting_q  <= counting_d;
				indicator_q <= indicator_d;
				remaining_q <= remaining_d;
				quarter_q   <= quarter_d;
				if (sample_take) begin
					temp_q   <= in_temp;
					hund_q   <= hund_w;
					tens_q   <= tens_w;
					units_q  <= units_w;
					tenths_q <= tenths_w;
				end
			end
			if (in_ready) out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.running            <= counting_d;
			out_q.long_mode          <= mode_long_d;
			out_q.seconds_left       <= remaining_d;
			out_q.temperature_tenths <= sample_take ? in_temp : temp_q;
			out_q.digit_hundreds     <= sample_take ? hund_w : hund_q;
			out_q.digit_tens         <= sample_take ? tens_w : tens_q;
			out_q.digit_units        <= sample_take ? units_w : units_q;
			out_q.digit_tenths       <= sample_take ? tenths_w : tenths_q;
			out_q.led_on             <= counting_d && indicator_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule

### hdl/oven_countdown_and_temperature_gauge_top.sv
// ----------------------------------------------------------------------------
// oven_countdown_and_temperature_gauge_top
// event-driven oven countdown with temperature gauge and over-temperature led
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_*       in   16     action, adc_value
//  m_*       out  40     running, long_mode, seconds_left, temperature, digits, led
//  cfg_*     in   2+10   register index, write data
//
//  one beat per cycle sustained while m_ is not stalled; a beat's result leaves
//  through the input register, scaling estimate, scaling correction and result
//  register. state and result are written in the last stage, in beat order.
//  a stall on m_ holds back each stage only once it is full.
//  reset clears all control and countdown state, registers take reset values.
module oven_countdown_and_temperature_gauge_top #(
	parameter int QUARTERS_PER_SECOND = ocg_pkg::QUARTERS_PER_SECOND_DEF,
	parameter int ADC_FULL_SCALE      = ocg_pkg::ADC_FULL_SCALE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ocg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ocg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// action[2:0], adc_value[12:3], zero fill
	input  logic [ocg_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// running[0], long_mode[1], seconds_left[9:2], temperature_tenths[19:10],
	// digit_hundreds[20], digit_tens[24:21], digit_units[28:25],
	// digit_tenths[32:29], led_on[33], zero fill
	output logic [ocg_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import ocg_pkg::*;

	logic              tmp_valid, tmp_ready;
	action_t           tmp_action;
	logic [TEMP_W-1:0] tmp_temp;
	result_t           res;

	ocg_temp #(
		.ADC_FULL_SCALE (ADC_FULL_SCALE)
	) u_temp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (action_t'(s_tdata[ACTION_W-1:0])),
		.in_adc     (s_tdata[ACTION_W +: ADC_W]),
		.out_valid  (tmp_valid),
		.out_ready  (tmp_ready),
		.out_action (tmp_action),
		.out_temp   (tmp_temp)
	);

	ocg_ctrl #(
		.QUARTERS_PER_SECOND (QUARTERS_PER_SECOND)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (tmp_valid),
		.in_ready   (tmp_ready),
		.in_action  (tmp_action),
		.in_temp    (tmp_temp),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (res)
	);

	assign m_tdata = {(OUT_TDATA_W - RES_W)'(0),
		res.led_on, res.digit_tenths, res.digit_units, res.digit_tens,
		res.digit_hundreds, res.temperature_tenths, res.seconds_left,
		res.long_mode, res.running};

endmodule

### hdl/ocg_checker.sv
// ----------------------------------------------------------------------------
// ocg_checker
// port-level checks on the result stream of the oven countdown block
// ----------------------------------------------------------------------------
module ocg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ocg_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import ocg_pkg::*;

	// led only while a countdown runs
	a_led_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[33] || m_tdata[0]))
		else $error("led on while not running");

	// temperature never above full scale, hundreds digit only at full scale
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:10] <= 10'd1000) &&
			(m_tdata[20] == (m_tdata[19:10] == 10'd1000)))
		else $error("temperature out of range");

	// decimal digits stay decimal
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:21] <= 4'd9) && (m_tdata[28:25] <= 4'd9) &&
			(m_tdata[32:29] <= 4'd9))
		else $error("digit out of range");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled beat changed");

endmodule

bind oven_countdown_and_temperature_gauge_top ocg_checker u_ocg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
